>>> sv/positional_ordered_list_defines.svh
// Assertion macros shared by the list RTL
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

// Condition holds at every edge out of reset
`define POL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define POL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/pol_pkg.sv
package pol_pkg;

  // Sizing
  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int POS_W       = 5;
  localparam int FIELD_W     = 32;
  localparam int COUNT_W     = 5;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Operation codes
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_INS_AT    = 3'd2;
  localparam logic [2:0] OP_REM_FRONT = 3'd3;
  localparam logic [2:0] OP_REM_BACK  = 3'd4;
  localparam logic [2:0] OP_REM_AT    = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CMP_W-1:0]       cmp_t;

  // Where a command lands in the list
  typedef enum logic [1:0] {
    WHERE_FRONT = 2'd0,
    WHERE_BACK  = 2'd1,
    WHERE_AT    = 2'd2
  } where_t;

  typedef struct packed {
    logic [2:0]       operation;
    logic [POS_W-1:0] position;
    logic [31:0]      new_value;
  } req_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] removed_value;
    logic [COUNT_W-1:0] count_now;
  } rsp_word_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic             is_insert;
    logic             bad_op;
    where_t           where;
    logic [POS_W-1:0] position;
    value_t           value;
  } cmd_t;

  function automatic logic [FIELD_W-1:0] to_field(value_t v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[FIELD_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] count_field(cnt_t c);
    logic [15:0] wide;
    wide = 16'(c);
    return wide[COUNT_W-1:0];
  endfunction

endpackage

>>> sv/pol_front.sv
module pol_front (
  input  logic               req_valid,
  output logic               req_stall,
  input  pol_pkg::req_word_t req,
  input  logic               q_full,
  output logic               q_push,
  output pol_pkg::cmd_t      q_cmd
);

  // Accept whenever the queue has room
  assign req_stall = q_full;
  assign q_push    = req_valid && !q_full;

  // Decode operation into kind and landing spot
  always_comb begin
    q_cmd.is_insert = 1'b0;
    q_cmd.bad_op    = 1'b0;
    q_cmd.where     = pol_pkg::WHERE_FRONT;
    q_cmd.position  = req.position;
    q_cmd.value     = pol_pkg::value_t'(req.new_value);
    case (req.operation)
      pol_pkg::OP_INS_FRONT: begin
        q_cmd.is_insert = 1'b1;
        q_cmd.where     = pol_pkg::WHERE_FRONT;
      end
      pol_pkg::OP_INS_BACK: begin
        q_cmd.is_insert = 1'b1;
        q_cmd.where     = pol_pkg::WHERE_BACK;
      end
      pol_pkg::OP_INS_AT: begin
        q_cmd.is_insert = 1'b1;
        q_cmd.where     = pol_pkg::WHERE_AT;
      end
      pol_pkg::OP_REM_FRONT: begin
        q_cmd.where = pol_pkg::WHERE_FRONT;
      end
      pol_pkg::OP_REM_BACK: begin
        q_cmd.where = pol_pkg::WHERE_BACK;
      end
      pol_pkg::OP_REM_AT: begin
        q_cmd.where = pol_pkg::WHERE_AT;
      end
      default: begin
        q_cmd.bad_op = 1'b1;
      end
    endcase
  end

endmodule

>>> sv/pol_queue.sv
`include "positional_ordered_list_defines.svh"

module pol_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pol_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          avail,
  output pol_pkg::cmd_t head
);

  localparam logic [1:0] DEPTH = 2'd2;

  pol_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full  = (fill == DEPTH);
  assign avail = (fill != 2'd0);
  assign head  = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  `POL_ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into full queue")
  `POL_ASSERT_ALWAYS(a_no_underflow, !(pop && !avail), "pop from empty queue")

endmodule

>>> sv/pol_back.sv
`include "positional_ordered_list_defines.svh"

module pol_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_avail,
  input  pol_pkg::cmd_t      q_head,
  output logic               q_pop,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output pol_pkg::rsp_word_t rsp
);

  pol_pkg::value_t store [pol_pkg::CAPACITY];
  pol_pkg::cnt_t   cnt;

  pol_pkg::cmp_t   pos_c;
  pol_pkg::cmp_t   cnt_c;
  pol_pkg::cmp_t   idx_c;
  pol_pkg::idx_t   idx;
  logic [1:0]      status;
  logic            ok;
  pol_pkg::value_t got;

  // Take a command when the result register is free or draining
  assign q_pop = q_avail && (!rsp_valid || !rsp_stall);

  // Target index and status
  always_comb begin
    pos_c = pol_pkg::cmp_t'(q_head.position);
    cnt_c = pol_pkg::cmp_t'(cnt);
    case (q_head.where)
      pol_pkg::WHERE_FRONT: idx_c = '0;
      pol_pkg::WHERE_BACK:  idx_c = q_head.is_insert ? cnt_c : cnt_c - 1'b1;
      pol_pkg::WHERE_AT:    idx_c = pos_c;
      default:              idx_c = '0;
    endcase
    idx = idx_c[pol_pkg::IDX_W-1:0];

    if (q_head.bad_op) begin
      status = pol_pkg::ST_BADPOS;
    end else if (q_head.is_insert) begin
      if (idx_c > cnt_c) status = pol_pkg::ST_BADPOS;
      else if (cnt_c >= pol_pkg::cmp_t'(pol_pkg::CAPACITY)) status = pol_pkg::ST_FULL;
      else status = pol_pkg::ST_OK;
    end else begin
      if (cnt_c == '0) status = pol_pkg::ST_EMPTY;
      else if (idx_c >= cnt_c) status = pol_pkg::ST_BADPOS;
      else status = pol_pkg::ST_OK;
    end
    ok = (status == pol_pkg::ST_OK);
  end

  // Read port for removals
  always_comb begin
    got = '0;
    for (int i = 0; i < pol_pkg::CAPACITY; i++) begin
      if (idx == pol_pkg::idx_t'(i)) got = store[i];
    end
  end

  // Slot row: each slot compares its own index with the target
  for (genvar g = 0; g < pol_pkg::CAPACITY; g++) begin : g_slot
    pol_pkg::value_t from_prev;
    pol_pkg::value_t from_next;
    if (g == 0) begin : g_first
      assign from_prev = q_head.value;
    end else begin : g_mid
      assign from_prev = store[g-1];
    end
    if (g == pol_pkg::CAPACITY - 1) begin : g_last
      assign from_next = store[g];
    end else begin : g_inner
      assign from_next = store[g+1];
    end

    always_ff @(posedge clk) begin
      if (q_pop && ok) begin
        if (q_head.is_insert) begin
          if (pol_pkg::idx_t'(g) == idx) store[g] <= q_head.value;
          else if (pol_pkg::idx_t'(g) > idx) store[g] <= from_prev;
        end else if (pol_pkg::idx_t'(g) >= idx) begin
          store[g] <= from_next;
        end
      end
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (q_pop && ok) begin
      cnt <= q_head.is_insert ? pol_pkg::cnt_t'(cnt + 1'b1) : pol_pkg::cnt_t'(cnt - 1'b1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (q_pop) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rsp.status        <= status;
      rsp.removed_value <= (ok && !q_head.is_insert) ? pol_pkg::to_field(got) : '0;
      rsp.count_now     <= ok ? (q_head.is_insert ? pol_pkg::count_field(cnt + 1'b1)
                                                  : pol_pkg::count_field(cnt - 1'b1))
                              : pol_pkg::count_field(cnt);
    end
  end

  `POL_ASSERT_ALWAYS(a_cnt_bound, cnt <= pol_pkg::cnt_t'(pol_pkg::CAPACITY), "count past capacity")
  `POL_ASSERT_NEXT(a_ins_grows, q_pop && ok && q_head.is_insert, cnt == $past(cnt) + 1'b1, "insert did not grow list")
  `POL_ASSERT_NEXT(a_rem_shrinks, q_pop && ok && !q_head.is_insert, cnt == $past(cnt) - 1'b1, "remove did not shrink list")
  `POL_ASSERT_NEXT(a_rsp_count, q_pop, rsp.count_now == pol_pkg::count_field(cnt), "reported count differs from held count")

endmodule

>>> sv/positional_ordered_list.sv
// Bounded ordered list of up to CAPACITY handles with insert and remove at
// the front, the back or a given index; every request word yields exactly one
// response word with a status, the removed handle (zero unless a removal
// succeeded) and the entry count afterwards. The front decodes requests into
// a two-word command queue, and the back executes one command per cycle while
// the response side does not stall: the slots at and past the target shift in
// parallel, each comparing its own index with the target. A request passes
// through the command queue and then the result register before its response
// appears, and the block sustains one word per cycle while the response side
// does not stall. List storage is not cleared at reset; the count is.
module positional_ordered_list (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  pol_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output pol_pkg::rsp_word_t rsp
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_avail;
  pol_pkg::cmd_t q_cmd;
  pol_pkg::cmd_t q_head;

  pol_front u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  pol_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  pol_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
